FILE: sv/lfsod_pkg.sv
package lfsod_pkg;

  localparam int unsigned RangeW = 16;
  localparam int unsigned AngleW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_HIT_RANGE_MAX = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RANGE_FLOOR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RANGE_CEILING = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_START_ANGLE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_STEP = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SECTOR_CENTER = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SECTOR_HALFWIDTH = 3'd6;

  // reset values
  localparam logic [RangeW-1:0] RST_HIT_RANGE_MAX = 16'd1000;
  localparam logic [RangeW-1:0] RST_RANGE_FLOOR = 16'd0;
  localparam logic [RangeW-1:0] RST_RANGE_CEILING = 16'hFFFF;
  localparam logic [AngleW-1:0] RST_START_ANGLE = 32'h0000_0000;
  localparam logic [AngleW-1:0] RST_ANGLE_STEP = 32'h0000_0000;
  localparam logic [AngleW-1:0] RST_SECTOR_CENTER = 32'hC000_0000;
  localparam logic [AngleW-1:0] RST_SECTOR_HALFWIDTH = 32'd357913941;

  typedef struct packed {
    logic [RangeW-1:0] hit_range_max;
    logic [RangeW-1:0] range_floor;
    logic [RangeW-1:0] range_ceiling;
    logic signed [AngleW-1:0] start_angle;
    logic signed [AngleW-1:0] angle_step;
    logic signed [AngleW-1:0] sector_center;
    logic [AngleW-1:0] sector_halfwidth;
  } cfg_t;

  // one sample held in the input stage
  typedef struct packed {
    logic [RangeW-1:0] range_mm;
    logic not_finite;
    logic last;
    logic [AngleW-1:0] angle;
  } sample_t;

endpackage

FILE: sv/lidar_front_sector_obstacle_detect.sv
// lidar front sector obstacle detector
//
// input channel: one range sample per transfer (range_mm_i, not_finite_i,
// last_i) on in_valid_i / in_ready_o. the sample flagged last closes a scan.
// output channel: one obstacle_o bit per scan on out_valid_o / out_ready_i,
// high when any sample of the scan was finite, inside the range window, at most
// hit_range_max and within the sector half width of the sector center.
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
// indexes beyond the register list are dropped. write only while idle.
// throughput: one sample per cycle outside a stall, set by a single input
// register stage that feeds the hit test and a single result register.
// result path: a last sample passes two register stages, the input stage
// and then the result register that drives out_valid_o.
// stall: while the result register is full and out_ready_i is low, samples
// without last still flow through; a last sample waits in the input stage
// and in_ready_o drops behind it.
// reset: registers return to their defaults, the scan restarts at
// start_angle with no hit recorded, and both stages empty.
module lidar_front_sector_obstacle_detect (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [lfsod_pkg::RangeW-1:0] range_mm_i,
  input  logic not_finite_i,
  input  logic last_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic obstacle_o,
  input  logic cfg_we_i,
  input  logic [lfsod_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfsod_pkg::CfgDataW-1:0] cfg_data_i
);
  import lfsod_pkg::*;

  cfg_t cfg;
  logic in_xfer;
  logic [AngleW-1:0] beam_angle;

  // input stage
  sample_t s1_q, s1_d;
  logic s1_valid_q, s1_valid_d;
  logic s1_adv;
  logic hit;

  // scan accumulator and result register
  logic hit_seen_q, hit_seen_d;
  logic out_valid_q, out_valid_d;
  logic obstacle_q, obstacle_d;
  logic out_free;

  lfsod_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // beam angle is assigned as the sample is taken
  lfsod_angle u_angle (
    .clk_i,
    .rst_ni,
    .accept_i      (in_xfer),
    .last_i        (last_i),
    .start_angle_i (cfg.start_angle),
    .angle_step_i  (cfg.angle_step),
    .angle_o       (beam_angle)
  );

  lfsod_hit u_hit (
    .sample_i (s1_q),
    .cfg_i    (cfg),
    .hit_o    (hit)
  );

  // result slot frees up when empty or drained this cycle
  assign out_free = !out_valid_q || out_ready_i;
  // only a last sample needs the result slot
  assign s1_adv = s1_valid_q && (!s1_q.last || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer = in_valid_i && in_ready_o;

  always_comb begin
    s1_d = s1_q;
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_d.range_mm = range_mm_i;
      s1_d.not_finite = not_finite_i;
      s1_d.last = last_i;
      s1_d.angle = beam_angle;
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    hit_seen_d = hit_seen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    obstacle_d = obstacle_q;
    if (s1_adv) begin
      if (s1_q.last) begin
        // close the scan and clear for the next one
        obstacle_d = hit_seen_q || hit;
        out_valid_d = 1'b1;
        hit_seen_d = 1'b0;
      end else begin
        hit_seen_d = hit_seen_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hit_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      hit_seen_q <= hit_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    obstacle_q <= obstacle_d;
  end

  assign out_valid_o = out_valid_q;
  assign obstacle_o = obstacle_q;

endmodule

FILE: sv/lfsod_cfg.sv
module lfsod_cfg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [lfsod_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfsod_pkg::CfgDataW-1:0] cfg_data_i,
  output lfsod_pkg::cfg_t cfg_o
);
  import lfsod_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HIT_RANGE_MAX:    cfg_d.hit_range_max = cfg_data_i[RangeW-1:0];
        REG_RANGE_FLOOR:      cfg_d.range_floor = cfg_data_i[RangeW-1:0];
        REG_RANGE_CEILING:    cfg_d.range_ceiling = cfg_data_i[RangeW-1:0];
        REG_START_ANGLE:      cfg_d.start_angle = cfg_data_i[AngleW-1:0];
        REG_ANGLE_STEP:       cfg_d.angle_step = cfg_data_i[AngleW-1:0];
        REG_SECTOR_CENTER:    cfg_d.sector_center = cfg_data_i[AngleW-1:0];
        REG_SECTOR_HALFWIDTH: cfg_d.sector_halfwidth = cfg_data_i[AngleW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_range_max <= RST_HIT_RANGE_MAX;
      cfg_q.range_floor <= RST_RANGE_FLOOR;
      cfg_q.range_ceiling <= RST_RANGE_CEILING;
      cfg_q.start_angle <= RST_START_ANGLE;
      cfg_q.angle_step <= RST_ANGLE_STEP;
      cfg_q.sector_center <= RST_SECTOR_CENTER;
      cfg_q.sector_halfwidth <= RST_SECTOR_HALFWIDTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/lfsod_angle.sv
module lfsod_angle (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  logic last_i,
  input  logic [lfsod_pkg::AngleW-1:0] start_angle_i,
  input  logic [lfsod_pkg::AngleW-1:0] angle_step_i,
  output logic [lfsod_pkg::AngleW-1:0] angle_o
);
  import lfsod_pkg::*;

  logic [AngleW-1:0] beam_q, beam_d;
  logic scan_start_q, scan_start_d;

  // first sample of a scan takes the start angle
  assign angle_o = scan_start_q ? start_angle_i : beam_q;

  always_comb begin
    beam_d = beam_q;
    scan_start_d = scan_start_q;
    if (accept_i) begin
      beam_d = angle_o + angle_step_i;
      scan_start_d = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q <= '0;
      scan_start_q <= 1'b1;
    end else begin
      beam_q <= beam_d;
      scan_start_q <= scan_start_d;
    end
  end

endmodule

FILE: sv/lfsod_hit.sv
module lfsod_hit (
  input  lfsod_pkg::sample_t sample_i,
  input  lfsod_pkg::cfg_t cfg_i,
  output logic hit_o
);
  import lfsod_pkg::*;

  logic [AngleW-1:0] diff;
  logic [AngleW-1:0] gap;
  logic range_ok;
  logic angle_ok;

  always_comb begin
    diff = sample_i.angle - cfg_i.sector_center;
    // shortest distance magnitude, half a turn stays 2^31
    gap = diff[AngleW-1] ? (~diff + {{(AngleW-1){1'b0}}, 1'b1}) : diff;
    angle_ok = gap <= cfg_i.sector_halfwidth;
    range_ok = !sample_i.not_finite
             && (sample_i.range_mm > cfg_i.range_floor)
             && (sample_i.range_mm <= cfg_i.range_ceiling)
             && (sample_i.range_mm <= cfg_i.hit_range_max);
    hit_o = range_ok && angle_ok;
  end

endmodule
